// ===== rtl/core/efan_pkg.sv =====
`default_nettype none
package efan_pkg;

   localparam int MAX_STEPS_DEF = 16;
   localparam int WORD_W = 60;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] LONG_STEPS = CNT_W'(WORD_W - 1);
   localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(WORD_W / 2 - 1);

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/efan_unit.sv =====
`default_nettype none
module efan_unit
   import efan_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire unit_ctrl_type       ctrl,
   input  wire logic [WORD_W-1:0]   hi_init,
   input  wire logic [WORD_W-1:0]   lo_init,
   input  wire logic [WORD_W-1:0]   b_init,
   output unit_stat_type            stat,
   output logic [WORD_W-1:0]        hi,
   output logic [WORD_W-1:0]        lo,
   output logic [WORD_W-1:0]        b
);

   logic                busy_ff, done_ff;
   logic [CNT_W-1:0]    count_ff;
   op_type              op_ff;
   logic [WORD_W-1:0]   hi_ff, lo_ff, b_ff;
   logic [WORD_W-1:0]   hi_in, lo_in, b_in;

   logic [WORD_W:0]     sum;
   logic [WORD_W:0]     rem2;
   logic [WORD_W+1:0]   diff;
   logic [WORD_W-1:0]   sq_rem;
   logic [WORD_W-1:0]   trial;
   logic [WORD_W:0]     sq_diff;

   // One step of shift-add multiply, restoring divide or digit-by-digit root.
   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, b_ff} : '0);
      rem2    = {hi_ff, lo_ff[WORD_W-1]};
      diff    = {1'b0, rem2} - {2'b00, b_ff};
      sq_rem  = {hi_ff[WORD_W-3:0], lo_ff[WORD_W-1:WORD_W-2]};
      trial   = {b_ff[WORD_W-3:0], 2'b01};
      sq_diff = {1'b0, sq_rem} - {1'b0, trial};
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      case (op_ff)
         OP_MUL: begin
            hi_in = sum[WORD_W:1];
            lo_in = {sum[0], lo_ff[WORD_W-1:1]};
         end
         OP_DIV: begin
            hi_in = diff[WORD_W+1] ? rem2[WORD_W-1:0] : diff[WORD_W-1:0];
            lo_in = {lo_ff[WORD_W-2:0], ~diff[WORD_W+1]};
         end
         OP_SQRT: begin
            hi_in = sq_diff[WORD_W] ? sq_rem : sq_diff[WORD_W-1:0];
            lo_in = {lo_ff[WORD_W-3:0], 2'b00};
            b_in  = {b_ff[WORD_W-2:0], ~sq_diff[WORD_W]};
         end
         default: begin
            hi_in = hi_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
         op_ff    <= OP_MUL;
      end else begin
         done_ff <= busy_ff && !ctrl.start && (count_ff == '0);
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            op_ff    <= ctrl.op;
            count_ff <= (ctrl.op == OP_SQRT) ? ROOT_STEPS : LONG_STEPS;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (ctrl.start) begin
         hi_ff <= hi_init;
         lo_ff <= lo_init;
         b_ff  <= b_init;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         b_ff  <= b_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign hi = hi_ff;
   assign lo = lo_ff;
   assign b  = b_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ellipse_fan_tessellator.sv =====
// Operation: each column runs three 60-step passes and one 30-step root pass of the shared
// shift/subtract unit plus control; the first column emits nothing.
// A request with N steps (after clamping) occupies the block for 2N-1 columns plus the
// two closing triangles, and result stalls lengthen this.
// Throughput: one request at a time; req_stall stays high until the last triangle is loaded.
// Reset: synchronous, active high; clears the sequencer, the unit and the output valid.
`default_nettype none
module ellipse_fan_tessellator
   import efan_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [29:0]        req_x_radius,
   input  wire logic [29:0]        req_y_radius,
   input  wire logic [4:0]         req_steps_per_quarter,
   input  wire logic signed [30:0] req_origin_x,
   input  wire logic signed [30:0] req_origin_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_v0_x,
   output logic signed [31:0]      rsp_v0_y,
   output logic signed [31:0]      rsp_v1_x,
   output logic signed [31:0]      rsp_v1_y,
   output logic signed [31:0]      rsp_v2_x,
   output logic signed [31:0]      rsp_v2_y,
   output logic                    rsp_last_triangle
);

   localparam logic [4:0] MAX_N = 5'(MAX_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_COL, S_QW, S_XK, S_PROD, S_MULW, S_DIVS, S_DIVW,
      S_SQS, S_SQW, S_VERT, S_TOP, S_BOT, S_NEXT, S_CL1, S_CL2
   } state_type;

   state_type             state_ff;
   logic [4:0]            k_ff, n_ff, cols_ff;
   logic [29:0]           xr_ff, a_ff;
   logic [WORD_W-1:0]     ysq_ff, den_ff;
   logic signed [31:0]    ox_ff, oy_ff, bx_ff, ex_ff, xk_ff;
   logic signed [31:0]    cur_x_ff, cur_ty_ff, cur_by_ff;
   logic signed [31:0]    prev_x_ff, prev_ty_ff, prev_by_ff;
   logic signed [31:0]    v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic                  last_ff, rsp_valid_ff;

   unit_ctrl_type         ctrl;
   unit_stat_type         stat;
   logic [WORD_W-1:0]     hi_init, lo_init, b_init, u_hi, u_lo, u_b;

   logic                  slot_free;
   logic                  load_out;
   logic [4:0]            n_in;
   logic signed [31:0]    xk_in, y_in;
   logic [WORD_W-1:0]     p_in;

   efan_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .hi_init (hi_init),
      .lo_init (lo_init),
      .b_init  (b_init),
      .stat    (stat),
      .hi      (u_hi),
      .lo      (u_lo),
      .b       (u_b)
   );

   always_comb begin
      ctrl.start = 1'b0;
      ctrl.op    = OP_MUL;
      hi_init    = '0;
      lo_init    = '0;
      b_init     = '0;
      case (state_ff)
         S_COL: begin
            ctrl.start = 1'b1;
            ctrl.op    = OP_DIV;
            lo_init    = WORD_W'(35'(k_ff) * 35'(xr_ff));
            b_init     = WORD_W'(n_ff);
         end
         S_PROD: begin
            ctrl.start = 1'b1;
            ctrl.op    = OP_MUL;
            lo_init    = p_in;
            b_init     = ysq_ff;
         end
         S_DIVS: begin
            ctrl.start = 1'b1;
            ctrl.op    = OP_DIV;
            hi_init    = u_hi;
            lo_init    = u_lo;
            b_init     = den_ff;
         end
         S_SQS: begin
            ctrl.start = 1'b1;
            ctrl.op    = OP_SQRT;
            lo_init    = u_lo;
         end
         default: begin
            ctrl.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      load_out  = slot_free && (state_ff inside {S_TOP, S_BOT, S_CL1, S_CL2});
      if (req_steps_per_quarter == 5'd0) begin
         n_in = 5'd1;
      end else if (req_steps_per_quarter > MAX_N) begin
         n_in = MAX_N;
      end else begin
         n_in = req_steps_per_quarter;
      end
      xk_in = $signed({1'b0, u_lo[30:0]}) - $signed({2'b00, xr_ff});
      p_in  = WORD_W'(xr_ff - a_ff) * WORD_W'({1'b0, xr_ff} + {1'b0, a_ff});
      y_in  = (den_ff == '0) ? 32'sd0 : $signed({2'b00, u_b[29:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         rsp_valid_ff <= load_out || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_COL;
                  k_ff     <= 5'd1;
                  n_ff     <= n_in;
                  cols_ff  <= 5'((n_in << 1) - 5'd1);
                  xr_ff    <= req_x_radius;
                  ysq_ff   <= WORD_W'(req_y_radius) * WORD_W'(req_y_radius);
                  den_ff   <= WORD_W'(req_x_radius) * WORD_W'(req_x_radius);
                  ox_ff    <= 32'(req_origin_x);
                  oy_ff    <= 32'(req_origin_y);
                  bx_ff    <= 32'(req_origin_x) - $signed({2'b00, req_x_radius});
                  ex_ff    <= 32'(req_origin_x) + $signed({2'b00, req_x_radius});
               end
            end
            S_COL:  state_ff <= S_QW;
            S_QW: begin
               if (stat.done) begin
                  state_ff <= S_XK;
               end
            end
            S_XK: begin
               xk_ff    <= xk_in;
               a_ff     <= xk_in[31] ? 30'(-xk_in) : xk_in[29:0];
               state_ff <= S_PROD;
            end
            S_PROD: begin
               state_ff <= S_MULW;
            end
            S_MULW: begin
               if (stat.done) begin
                  state_ff <= S_DIVS;
               end
            end
            S_DIVS: state_ff <= S_DIVW;
            S_DIVW: begin
               if (stat.done) begin
                  state_ff <= S_SQS;
               end
            end
            S_SQS:  state_ff <= S_SQW;
            S_SQW: begin
               if (stat.done) begin
                  state_ff <= S_VERT;
               end
            end
            S_VERT: begin
               cur_x_ff  <= ox_ff + xk_ff;
               cur_ty_ff <= oy_ff + y_in;
               cur_by_ff <= oy_ff - y_in;
               state_ff  <= (k_ff >= 5'd2) ? S_TOP : S_NEXT;
            end
            S_TOP: begin
               if (slot_free) begin
                  v0x_ff <= bx_ff;    v0y_ff <= oy_ff;
                  v1x_ff <= cur_x_ff; v1y_ff <= cur_ty_ff;
                  v2x_ff <= prev_x_ff; v2y_ff <= prev_ty_ff;
                  last_ff  <= 1'b0;
                  state_ff <= S_BOT;
               end
            end
            S_BOT: begin
               if (slot_free) begin
                  v0x_ff <= bx_ff;     v0y_ff <= oy_ff;
                  v1x_ff <= prev_x_ff; v1y_ff <= prev_by_ff;
                  v2x_ff <= cur_x_ff;  v2y_ff <= cur_by_ff;
                  last_ff  <= 1'b0;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               prev_x_ff  <= cur_x_ff;
               prev_ty_ff <= cur_ty_ff;
               prev_by_ff <= cur_by_ff;
               if (k_ff == cols_ff) begin
                  state_ff <= S_CL1;
               end else begin
                  k_ff     <= k_ff + 5'd1;
                  state_ff <= S_COL;
               end
            end
            S_CL1: begin
               if (slot_free) begin
                  v0x_ff <= bx_ff;     v0y_ff <= oy_ff;
                  v1x_ff <= ex_ff;     v1y_ff <= oy_ff;
                  v2x_ff <= prev_x_ff; v2y_ff <= prev_ty_ff;
                  last_ff  <= 1'b0;
                  state_ff <= S_CL2;
               end
            end
            S_CL2: begin
               if (slot_free) begin
                  v0x_ff <= bx_ff;     v0y_ff <= oy_ff;
                  v1x_ff <= prev_x_ff; v1y_ff <= prev_by_ff;
                  v2x_ff <= ex_ff;     v2y_ff <= oy_ff;
                  last_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_v0_x          = v0x_ff;
   assign rsp_v0_y          = v0y_ff;
   assign rsp_v1_x          = v1x_ff;
   assign rsp_v1_y          = v1y_ff;
   assign rsp_v2_x          = v2x_ff;
   assign rsp_v2_y          = v2y_ff;
   assign rsp_last_triangle = last_ff;

   // The unit only reports completion while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == S_QW || state_ff == S_MULW ||
                     state_ff == S_DIVW || state_ff == S_SQW))
      else $error("unit finished outside a wait state");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (k_ff == 5'd1 && state_ff == S_COL))
      else $error("request transfer did not start at the first column");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (k_ff != 5'd0 && k_ff <= cols_ff))
      else $error("column index out of range");

endmodule
`default_nettype wire
